// ===== design/gbd_pkg.sv =====
`timescale 1ns / 1ps

package gbd_pkg;

   localparam int ByteWidth = 8;
   localparam int CodeWidth = 10;

   localparam logic [ByteWidth-1:0] TonosByte     = 8'ha2;
   localparam logic [ByteWidth-1:0] DialytikaByte = 8'ha3;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_END  = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK         = 1'b0,
      STATUS_INCOMPLETE = 1'b1
   } status_type;

   // decoder outcome for one item, handed from the decode logic to the top
   typedef struct packed {
      logic                 has_result;
      logic [CodeWidth-1:0] code_point;
      status_type           status;
      logic                 tonos_next;
      logic                 dialytika_next;
   } decode_type;

   // code point for a non-mark byte under the pending marks
   function automatic logic [CodeWidth-1:0] decode_byte(
      input logic [ByteWidth-1:0] b,
      input logic                 t,
      input logic                 d
   );
      logic [CodeWidth-1:0] cp;
      cp = {{(CodeWidth-ByteWidth){1'b0}}, b};
      case (b)
         8'he1: cp = t ? 10'h3ac : 10'h3b1;
         8'hc1: cp = t ? 10'h386 : 10'h391;
         8'he2: cp = 10'h3b2;
         8'hc2: cp = 10'h392;
         8'he4: cp = 10'h3b3;
         8'hc4: cp = 10'h393;
         8'he5: cp = 10'h3b4;
         8'hc5: cp = 10'h394;
         8'he6: cp = t ? 10'h3ad : 10'h3b5;
         8'hc6: cp = t ? 10'h388 : 10'h395;
         8'he9: cp = 10'h3b6;
         8'hc9: cp = 10'h396;
         8'hea: cp = t ? 10'h3ae : 10'h3b7;
         8'hca: cp = t ? 10'h389 : 10'h397;
         8'heb: cp = 10'h3b8;
         8'hcb: cp = 10'h398;
         8'hec: cp = t ? (d ? 10'h390 : 10'h3af) : (d ? 10'h3ca : 10'h3b9);
         // tonos wins over dialytika on the capitals
         8'hcc: cp = t ? 10'h38a : (d ? 10'h3aa : 10'h399);
         8'hed: cp = 10'h3ba;
         8'hcd: cp = 10'h39a;
         8'hee: cp = 10'h3bb;
         8'hce: cp = 10'h39b;
         8'hef: cp = 10'h3bc;
         8'hcf: cp = 10'h39c;
         8'hf0: cp = 10'h3bd;
         8'hd0: cp = 10'h39d;
         8'hf1: cp = 10'h3be;
         8'hd1: cp = 10'h39e;
         8'hf2: cp = t ? 10'h3cc : 10'h3bf;
         8'hd2: cp = t ? 10'h38c : 10'h39f;
         8'hf3: cp = 10'h3c0;
         8'hd3: cp = 10'h3a0;
         8'hf5: cp = 10'h3c1;
         8'hd5: cp = 10'h3a1;
         8'hf7: cp = 10'h3c2;
         8'hf6: cp = 10'h3c3;
         8'hd6: cp = 10'h3a3;
         8'hf8: cp = 10'h3c4;
         8'hd8: cp = 10'h3a4;
         8'hf9: cp = t ? (d ? 10'h3b0 : 10'h3cd) : (d ? 10'h3cb : 10'h3c5);
         8'hd9: cp = t ? 10'h38e : (d ? 10'h3ab : 10'h3a5);
         8'hfa: cp = 10'h3c6;
         8'hda: cp = 10'h3a6;
         8'hfb: cp = 10'h3c7;
         8'hdb: cp = 10'h3a7;
         8'hfc: cp = 10'h3c8;
         8'hdc: cp = 10'h3a8;
         8'hfd: cp = t ? 10'h3ce : 10'h3c9;
         8'hdd: cp = t ? 10'h38f : 10'h3a9;
         default: cp = {{(CodeWidth-ByteWidth){1'b0}}, b};
      endcase
      return cp;
   endfunction

endpackage

// ===== design/gbd_decode.sv =====
`timescale 1ns / 1ps

module gbd_decode (
   input  gbd_pkg::op_type              op,
   input  logic [gbd_pkg::ByteWidth-1:0] byte_value,
   input  logic                          tonos,
   input  logic                          dialytika,
   output gbd_pkg::decode_type           result
);
   import gbd_pkg::*;

   always_comb begin
      result.has_result     = 1'b0;
      result.code_point     = '0;
      result.status         = STATUS_OK;
      result.tonos_next     = tonos;
      result.dialytika_next = dialytika;
      if (op == OP_END) begin
         // dangling marks are reported once and dropped
         if (tonos || dialytika) begin
            result.has_result     = 1'b1;
            result.status         = STATUS_INCOMPLETE;
            result.tonos_next     = 1'b0;
            result.dialytika_next = 1'b0;
         end
      end else if (byte_value == TonosByte) begin
         result.tonos_next = 1'b1;
      end else if (byte_value == DialytikaByte) begin
         result.dialytika_next = 1'b1;
      end else begin
         result.has_result     = 1'b1;
         result.code_point     = decode_byte(byte_value, tonos, dialytika);
         result.tonos_next     = 1'b0;
         result.dialytika_next = 1'b0;
      end
   end

endmodule

// ===== design/iso5428_greek_byte_decoder_top.sv =====
`timescale 1ns / 1ps

// ISO 5428 Greek byte decoder.
// Request channel (req_valid/req_ready): one item per request, req_op selects
// a data byte or the end-of-data marker, req_byte_value carries the byte.
// Response channel (rsp_valid/rsp_ready): one Unicode code point with a
// status bit. Mark bytes give no response; the following letter picks up the
// marks. End of data gives a response only when marks were left dangling.
// A request is held in the input register, then the table lookup writes its
// result into the response register, which drives rsp_valid.
// Throughput: one request per cycle unless the receiver stalls, set by the
// single lookup stage between the two registers; marks update in the same cycle.
// Reset clears both mark flags and empties both pipeline registers.
// When the receiver stalls, the response register holds its item and the
// input register keeps one more request; after that req_ready drops.
// Requests that give no response still drain while the response register is
// full.
module iso5428_greek_byte_decoder_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  gbd_pkg::op_type               req_op,
   input  logic [gbd_pkg::ByteWidth-1:0] req_byte_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gbd_pkg::CodeWidth-1:0] rsp_code_point,
   output gbd_pkg::status_type           rsp_status
);
   import gbd_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   op_type               in_op_ff;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 tonos_ff, tonos_in;
   logic                 dialytika_ff, dialytika_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CodeWidth-1:0] out_code_ff;
   status_type           out_status_ff;

   decode_type dec;
   logic       out_free;
   logic       advance;

   gbd_decode u_decode (
      .op         (in_op_ff),
      .byte_value (in_byte_ff),
      .tonos      (tonos_ff),
      .dialytika  (dialytika_ff),
      .result     (dec)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   // an item without a response may leave even if the output is full
   assign advance   = in_valid_ff && (out_free || !dec.has_result);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      tonos_in     = advance ? dec.tonos_next : tonos_ff;
      dialytika_in = advance ? dec.dialytika_next : dialytika_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance && dec.has_result) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         tonos_ff     <= 1'b0;
         dialytika_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         tonos_ff     <= tonos_in;
         dialytika_ff <= dialytika_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_byte_value;
      end
      if (advance && dec.has_result) begin
         out_code_ff   <= dec.code_point;
         out_status_ff <= dec.status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_code_ff;
   assign rsp_status     = out_status_ff;

   a_incomplete_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_INCOMPLETE |-> rsp_code_point == '0)
      else $error("incomplete status with nonzero code point");

   a_reset_marks: assert property (@(posedge clock)
      $past(reset) && !reset |-> !tonos_ff && !dialytika_ff && !in_valid_ff
      && !out_valid_ff)
      else $error("state not cleared by reset");

   a_letter_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_op_ff == OP_DATA && in_byte_ff != TonosByte
      && in_byte_ff != DialytikaByte |=> !tonos_ff && !dialytika_ff)
      else $error("marks survived a letter");

   a_tonos_set: assert property (@(posedge clock) disable iff (reset)
      advance && in_op_ff == OP_DATA && in_byte_ff == TonosByte |=> tonos_ff)
      else $error("tonos byte did not set the mark");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance && dec.has_result |=> rsp_valid)
      else $error("decoded request lost");

endmodule
